// ----- rtl/core/worst_fit_composition_allocator_top_defines.svh -----
// Assertion macros for the worst-fit composition allocator.
// Included by the modules that carry concurrent assertions.
`ifndef WORST_FIT_COMPOSITION_ALLOCATOR_TOP_DEFINES_SVH
`define WORST_FIT_COMPOSITION_ALLOCATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WFCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define WFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/wfca_pkg.sv -----
// Package of the worst-fit composition allocator: sizes, state codes, types.
// No dependencies.
package wfca_pkg;
    localparam int RACKS = 8;
    localparam int SLOTS_PER_RACK = 8;
    localparam int DEVICES_PER_RACK = 16;
    localparam int NSLOTS = RACKS * SLOTS_PER_RACK;
    localparam int RW = $clog2(RACKS);
    localparam int SW = $clog2(SLOTS_PER_RACK);
    localparam int IW = $clog2(NSLOTS);
    localparam int DW = 5;
    localparam int BW = 20;
    localparam int CW = 24;
    localparam int QW = 25; // quotient width of the divider

    localparam logic [0:0] CFG_DEVICE_BANDWIDTH = 1'b0;
    localparam logic [0:0] CFG_DEVICE_CAPACITY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DIV_BW,
        ST_DIV_CAP,
        ST_RACK,
        ST_SLOT,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Control bundle between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [23:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } div_sts_t;
endpackage

// ----- rtl/core/wfca_divider.sv -----
// Restoring ceiling divider, one quotient bit per cycle.
// Depends on wfca_pkg.
module wfca_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  wfca_pkg::div_ctl_t ctl,
    output wfca_pkg::div_sts_t sts
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] num_reg, num_next;
    logic [23:0] den_reg, den_next;
    logic [23:0] q_reg, q_next;
    logic        done_reg, done_next;
    logic [24:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        den_next = den_reg;
        q_next = q_reg;
        done_next = 1'b0;
        shifted = {rem_reg[23:0], num_reg[23]};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd24;
            rem_next = '0;
            num_next = ctl.dividend;
            den_next = ctl.divisor;
            q_next = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[22:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next = {q_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next = {q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    // Ceiling: add one when a remainder is left.
    assign sts.done = done_reg;
    assign sts.quot = {1'b0, q_reg} + {24'd0, (rem_reg != 25'd0)};
endmodule

// ----- rtl/core/worst_fit_composition_allocator_top.sv -----
// Worst-fit composition allocator. One request word is taken when s_tready is
// high; s_tready stays low until the result word has been taken on m_. A request
// first goes through the slot scan, which reads the slot memory one entry per
// cycle. When a composition fits, an update step writes the reduced spare
// figures back. When none fits, two divisions on the shared divider, a walk over
// the racks, a walk over the slots of the chosen rack and a multiply step follow
// before the result word is offered.
// Depends on wfca_pkg, wfca_divider and the defines header.
`include "worst_fit_composition_allocator_top_defines.svh"
module worst_fit_composition_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // req_bandwidth[15:0], req_capacity[35:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // granted, rack_index, slot_index, opened_new,
                                  // device_count, spare_bandwidth, spare_capacity
);
    localparam int IW = wfca_pkg::IW;
    localparam int RW = wfca_pkg::RW;
    localparam int SW = wfca_pkg::SW;

    wfca_pkg::state_t state_reg, state_next;

    logic [15:0] dbw_reg;
    logic [19:0] dcap_reg;
    logic [15:0] bw_reg;
    logic [19:0] cap_reg;
    logic [15:0] dbw_eff;
    logic [19:0] dcap_eff;

    logic [wfca_pkg::NSLOTS-1:0] in_use_reg;
    logic [4:0] rack_free_reg [wfca_pkg::RACKS];

    // Slot memory: spare bandwidth, spare capacity, devices.
    logic [48:0] mem [wfca_pkg::NSLOTS];
    logic [48:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [48:0]   wr_data;

    logic [IW:0]   idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [24:0]   best_left_reg, best_left_next;
    logic [IW-1:0] best_reg, best_next;
    logic [IW-1:0] scan_addr_reg;
    logic          scan_live_reg;
    logic [24:0]   nb_reg, nb_next;
    logic [24:0]   need_reg, need_next;
    logic [RW-1:0] rack_reg, rack_next;
    logic [4:0]    rspare_reg, rspare_next;
    logic          rfound_reg, rfound_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [20:0]   sbw_reg, sbw_next;
    logic [24:0]   scap_reg, scap_next;
    logic [63:0]   out_reg, out_next;
    logic          ov_reg;

    wfca_pkg::div_ctl_t div_ctl;
    wfca_pkg::div_sts_t div_sts;

    wfca_divider u_div (.clk(clk), .rst_n(rst_n), .ctl(div_ctl), .sts(div_sts));

    logic [19:0] e_bw;
    logic [23:0] e_cap;
    logic [4:0]  e_dev;
    logic        fits;
    logic [24:0] left;
    logic [IW-1:0] open_idx;

    assign s_tready = (state_reg == wfca_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;
    // A register value of zero counts as one device unit.
    assign dbw_eff = (dbw_reg == 16'd0) ? 16'd1 : dbw_reg;
    assign dcap_eff = (dcap_reg == 20'd0) ? 20'd1 : dcap_reg;
    assign {e_dev, e_cap, e_bw} = rd_data_reg;
    assign fits = scan_live_reg && in_use_reg[scan_addr_reg]
                  && (e_bw >= {4'd0, bw_reg}) && (e_cap >= {4'd0, cap_reg});
    assign left = {5'd0, e_bw - {4'd0, bw_reg}} + {1'd0, e_cap - {4'd0, cap_reg}};
    assign open_idx = {rack_reg, slot_reg};
    // Once the scan index has run out, the best slot is read for the update.
    assign rd_addr = (state_reg == wfca_pkg::ST_SCAN_RD ||
                      (state_reg == wfca_pkg::ST_SCAN &&
                       idx_reg != wfca_pkg::NSLOTS[IW:0]))
                     ? idx_reg[IW-1:0] : best_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfca_pkg::ST_IDLE:    if (s_tvalid) state_next = wfca_pkg::ST_SCAN_RD;
            wfca_pkg::ST_SCAN_RD: state_next = wfca_pkg::ST_SCAN;
            wfca_pkg::ST_SCAN:
                if (!scan_live_reg && idx_reg == wfca_pkg::NSLOTS[IW:0])
                    state_next = found_reg ? wfca_pkg::ST_UPDATE : wfca_pkg::ST_DIV_BW;
            wfca_pkg::ST_DIV_BW:  if (div_sts.done) state_next = wfca_pkg::ST_DIV_CAP;
            wfca_pkg::ST_DIV_CAP: if (div_sts.done) state_next = wfca_pkg::ST_RACK;
            wfca_pkg::ST_RACK:
                if (idx_reg == wfca_pkg::RACKS[IW:0])
                    state_next = rfound_reg ? wfca_pkg::ST_SLOT : wfca_pkg::ST_DONE;
            wfca_pkg::ST_SLOT:
                if (!in_use_reg[open_idx]) state_next = wfca_pkg::ST_MUL;
                else if (slot_reg == SW'(wfca_pkg::SLOTS_PER_RACK - 1))
                    state_next = wfca_pkg::ST_DONE;
            wfca_pkg::ST_MUL:     state_next = wfca_pkg::ST_DONE;
            wfca_pkg::ST_UPDATE:  state_next = wfca_pkg::ST_DONE;
            wfca_pkg::ST_DONE:    if (!ov_reg) state_next = wfca_pkg::ST_IDLE;
            default:              state_next = wfca_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        found_next = found_reg;
        best_left_next = best_left_reg;
        best_next = best_reg;
        nb_next = nb_reg;
        need_next = need_reg;
        rack_next = rack_reg;
        rspare_next = rspare_reg;
        rfound_next = rfound_reg;
        slot_next = slot_reg;
        sbw_next = sbw_reg;
        scap_next = scap_reg;
        out_next = out_reg;
        mem_we = 1'b0;
        wr_addr = best_reg;
        wr_data = {e_dev, e_cap - {4'd0, cap_reg}, e_bw - {4'd0, bw_reg}};
        div_ctl.start = 1'b0;
        div_ctl.dividend = {8'd0, bw_reg};
        div_ctl.divisor = {8'd0, dbw_eff};
        case (state_reg)
            wfca_pkg::ST_IDLE:
            begin
                idx_next = '0;
                found_next = 1'b0;
                best_left_next = '0;
                best_next = '0;
                rfound_next = 1'b0;
                out_next = '0;
            end
            wfca_pkg::ST_SCAN_RD: idx_next = idx_reg + 1'b1;
            wfca_pkg::ST_SCAN:
            begin
                if (scan_live_reg && idx_reg != wfca_pkg::NSLOTS[IW:0])
                    idx_next = idx_reg + 1'b1;
                if (fits && (!found_reg || left > best_left_reg))
                begin
                    found_next = 1'b1;
                    best_left_next = left;
                    best_next = scan_addr_reg;
                end
                if (!scan_live_reg && idx_reg == wfca_pkg::NSLOTS[IW:0] && !found_reg)
                    div_ctl.start = 1'b1;
            end
            wfca_pkg::ST_DIV_BW:
            begin
                if (div_sts.done)
                begin
                    nb_next = div_sts.quot;
                    div_ctl.start = 1'b1;
                    div_ctl.dividend = {4'd0, cap_reg};
                    div_ctl.divisor = {4'd0, dcap_eff};
                end
            end
            wfca_pkg::ST_DIV_CAP:
            begin
                if (div_sts.done)
                begin
                    need_next = (nb_reg > div_sts.quot) ? nb_reg : div_sts.quot;
                    idx_next = '0;
                end
            end
            wfca_pkg::ST_RACK:
            begin
                if (idx_reg != wfca_pkg::RACKS[IW:0])
                begin
                    idx_next = idx_reg + 1'b1;
                    if ({20'd0, rack_free_reg[idx_reg[RW-1:0]]} >= need_reg
                        && (!rfound_reg ||
                            rack_free_reg[idx_reg[RW-1:0]] - need_reg[4:0] > rspare_reg))
                    begin
                        rfound_next = 1'b1;
                        rspare_next = rack_free_reg[idx_reg[RW-1:0]] - need_reg[4:0];
                        rack_next = idx_reg[RW-1:0];
                    end
                end
                slot_next = '0;
            end
            wfca_pkg::ST_SLOT:
                if (in_use_reg[open_idx]) slot_next = slot_reg + 1'b1;
            wfca_pkg::ST_MUL:
            begin
                sbw_next = ({16'd0, need_reg[4:0]} * {5'd0, dbw_eff}) - {5'd0, bw_reg};
                scap_next = ({20'd0, need_reg[4:0]} * {5'd0, dcap_eff}) - {5'd0, cap_reg};
                mem_we = 1'b1;
                wr_addr = open_idx;
                wr_data = {need_reg[4:0], scap_next[23:0], sbw_next[19:0]};
            end
            wfca_pkg::ST_UPDATE:
            begin
                mem_we = 1'b1;
                out_next = {7'd0, wr_data[43:20], wr_data[19:0], e_dev, 1'b0,
                            best_reg[SW-1:0], best_reg[IW-1:SW], 1'b1};
            end
            default: ;
        endcase
    end

    // Write of a new composition happens on entry to DONE from MUL.
    logic open_commit;
    assign open_commit = (state_reg == wfca_pkg::ST_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfca_pkg::ST_IDLE;
            dbw_reg <= 16'd1;
            dcap_reg <= 20'd1;
            in_use_reg <= '0;
            for (int r = 0; r < wfca_pkg::RACKS; r++)
                rack_free_reg[r] <= 5'(wfca_pkg::DEVICES_PER_RACK);
            ov_reg <= 1'b0;
            scan_live_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == wfca_pkg::CFG_DEVICE_BANDWIDTH)
                dbw_reg <= cfg_data[15:0];
            if (cfg_we && cfg_index == wfca_pkg::CFG_DEVICE_CAPACITY)
                dcap_reg <= cfg_data;
            scan_live_reg <= (state_reg == wfca_pkg::ST_SCAN_RD) ||
                             (state_reg == wfca_pkg::ST_SCAN &&
                              idx_reg != wfca_pkg::NSLOTS[IW:0]);
            if (open_commit)
            begin
                in_use_reg[open_idx] <= 1'b1;
                rack_free_reg[rack_reg] <= rack_free_reg[rack_reg] - need_reg[4:0];
            end
            if (m_tvalid && m_tready)
                ov_reg <= 1'b0;
            else if (state_reg != wfca_pkg::ST_DONE && state_next == wfca_pkg::ST_DONE)
                ov_reg <= 1'b1;
        end
    end

    logic [63:0] open_word;
    assign open_word = {7'd0, scap_next[23:0], sbw_next[19:0], need_reg[4:0], 1'b1,
                        slot_reg, rack_reg, 1'b1};

    always_ff @(posedge clk)
    begin
        if (state_reg == wfca_pkg::ST_IDLE && s_tvalid)
        begin
            bw_reg <= s_tdata[15:0];
            cap_reg <= s_tdata[35:16];
        end
        scan_addr_reg <= idx_reg[IW-1:0];
        idx_reg <= idx_next;
        found_reg <= found_next;
        best_left_reg <= best_left_next;
        best_reg <= best_next;
        nb_reg <= nb_next;
        need_reg <= need_next;
        rack_reg <= rack_next;
        rspare_reg <= rspare_next;
        rfound_reg <= rfound_next;
        slot_reg <= slot_next;
        sbw_reg <= sbw_next;
        scap_reg <= scap_next;
        out_reg <= open_commit ? open_word : out_next;
    end

    `WFCA_ASSERT_IMP(a_busy_not_ready, clk, rst_n,
        state_reg != wfca_pkg::ST_IDLE, !s_tready)
    `WFCA_ASSERT_NEXT(a_hold_out, clk, rst_n,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `WFCA_ASSERT_IMP(a_ref_granted, clk, rst_n,
        m_tvalid && !m_tdata[0], m_tdata == 64'd0)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for worst_fit_composition_allocator_top.
// Drives request words and checks every result word against a built-in predictor.
// Depends on wfca_pkg and the RTL of the allocator.
`timescale 1ns / 1ps
module tb;
    // Result word layout, lowest bit first: granted, rack, slot, opened,
    // devices, spare bandwidth, spare capacity, zero fill.
    typedef struct packed {
        logic [6:0]  fill;
        logic [23:0] spare_cap;
        logic [19:0] spare_bw;
        logic [4:0]  devices;
        logic        opened;
        logic [2:0]  slot;
        logic [2:0]  rack;
        logic        granted;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // req_bandwidth[15:0], req_capacity[35:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // granted, rack_index, slot_index, opened_new,
                            // device_count, spare_bandwidth, spare_capacity

    worst_fit_composition_allocator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Allocator image kept by the testbench.
    longint unsigned unit_bw;
    longint unsigned unit_cap;
    bit              comp_used [wfca_pkg::NSLOTS];
    longint unsigned comp_bw [wfca_pkg::NSLOTS];
    longint unsigned comp_cap [wfca_pkg::NSLOTS];
    longint unsigned comp_devs [wfca_pkg::NSLOTS];
    longint unsigned rack_free [wfca_pkg::RACKS];

    alloc_result_t pending_grants[$];
    int            mismatches;
    int            unexpected;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("worst_fit_composition_allocator_top regression: fail");
        $finish;
    end

    function automatic longint unsigned div_up(longint unsigned a, longint unsigned d);
        return (a + d - 1) / d;
    endfunction

    function automatic alloc_result_t place_request(longint unsigned bw,
                                                    longint unsigned cap);
        alloc_result_t   res;
        bit              hit;
        longint unsigned best_left;
        longint unsigned left;
        int              best;
        longint unsigned dbw;
        longint unsigned dcap;
        longint unsigned need;
        longint unsigned nb;
        longint unsigned nc;
        bit              rack_hit;
        longint unsigned best_spare;
        int              rk;
        int              sl;
        int              idx;
        res = '0;
        hit = 0;
        best_left = 0;
        best = 0;
        dbw = (unit_bw == 0) ? 1 : unit_bw;
        dcap = (unit_cap == 0) ? 1 : unit_cap;
        for (int i = 0; i < wfca_pkg::NSLOTS; i++)
        begin
            if (comp_used[i] && comp_bw[i] >= bw && comp_cap[i] >= cap)
            begin
                left = (comp_bw[i] - bw) + (comp_cap[i] - cap);
                if (!hit || left > best_left)
                begin
                    hit = 1;
                    best_left = left;
                    best = i;
                end
            end
        end
        if (hit)
        begin
            comp_bw[best] -= bw;
            comp_cap[best] -= cap;
            idx = best;
        end
        else
        begin
            nb = div_up(bw, dbw);
            nc = div_up(cap, dcap);
            need = (nb > nc) ? nb : nc;
            rack_hit = 0;
            best_spare = 0;
            rk = 0;
            for (int r = 0; r < wfca_pkg::RACKS; r++)
            begin
                if (rack_free[r] >= need && (!rack_hit || rack_free[r] - need > best_spare))
                begin
                    rack_hit = 1;
                    best_spare = rack_free[r] - need;
                    rk = r;
                end
            end
            if (!rack_hit)
                return res;
            sl = wfca_pkg::SLOTS_PER_RACK;
            for (int s = wfca_pkg::SLOTS_PER_RACK - 1; s >= 0; s--)
                if (!comp_used[rk * wfca_pkg::SLOTS_PER_RACK + s])
                    sl = s;
            // A full rack refuses the request; no other rack is tried.
            if (sl >= wfca_pkg::SLOTS_PER_RACK)
                return res;
            idx = rk * wfca_pkg::SLOTS_PER_RACK + sl;
            rack_free[rk] -= need;
            comp_used[idx] = 1;
            comp_devs[idx] = need;
            comp_bw[idx] = need * dbw - bw;
            comp_cap[idx] = need * dcap - cap;
            res.opened = 1'b1;
        end
        res.granted = 1'b1;
        res.rack = 3'(idx / wfca_pkg::SLOTS_PER_RACK);
        res.slot = 3'(idx % wfca_pkg::SLOTS_PER_RACK);
        res.devices = comp_devs[idx][4:0];
        res.spare_bw = comp_bw[idx][19:0];
        res.spare_cap = comp_cap[idx][23:0];
        return res;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_grants.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch (exp/act): granted %0d/%0d rack %0d/%0d",
                            want.granted, got.granted, want.rack, got.rack,
                            " slot %0d/%0d open %0d/%0d dev %0d/%0d",
                            want.slot, got.slot, want.opened, got.opened,
                            want.devices, got.devices,
                            " bw %0d/%0d cap %0d/%0d",
                            want.spare_bw, got.spare_bw,
                            want.spare_cap, got.spare_cap);
                end
            end
        end
    end

    // Receiver back-pressure.
    initial
    begin
        int run;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800) : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                m_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic [15:0] bw, input logic [19:0] cap);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, cap, bw};
        do @(posedge clk); while (!s_tready);
        pending_grants = {pending_grants, place_request(64'(bw), 64'(cap))};
        gap = $urandom_range(0, 9);
        gap = (gap < 5) ? 0 : (gap < 9) ? $urandom_range(1, 5) : $urandom_range(20, 150);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        // A refused request still finishes its rack and slot walk.
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [19:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == wfca_pkg::CFG_DEVICE_BANDWIDTH)
            unit_bw = value[15:0];
        else
            unit_cap = value;
    endtask

    task automatic test_directed();
        // Zero request with nothing open forms a composition of no devices.
        send_request(16'd0, 20'd0);
        send_request(16'd0, 20'd0);
        send_request(16'hFFFF, 20'hFFFFF);
        send_request(16'd16, 20'd0);
        send_request(16'd0, 20'd16);
        send_request(16'd17, 20'd1);
        drain_results();
        write_reg(wfca_pkg::CFG_DEVICE_BANDWIDTH, 20'hFFFFF);
        write_reg(wfca_pkg::CFG_DEVICE_CAPACITY, 20'hFFFFF);
        send_request(16'hFFFF, 20'hFFFFF);
        send_request(16'hFFFF, 20'h00000);
        send_request(16'h0000, 20'hFFFFF);
        send_request(16'h0001, 20'h00001);
        send_request(16'h8000, 20'h80000);
        drain_results();
        // Zero registers behave as one.
        write_reg(wfca_pkg::CFG_DEVICE_BANDWIDTH, 20'hF0000);
        write_reg(wfca_pkg::CFG_DEVICE_CAPACITY, 20'h00000);
        send_request(16'd3, 20'd2);
        send_request(16'd1, 20'd5);
        send_request(16'd0, 20'd0);
        drain_results();
    endtask

    task automatic test_random_phase(input logic [19:0] dbw, input logic [19:0] dcap,
                                     input int count, input bit hold_off);
        logic [15:0] bw;
        logic [19:0] cap;
        int          mode;
        write_reg(wfca_pkg::CFG_DEVICE_BANDWIDTH, dbw);
        write_reg(wfca_pkg::CFG_DEVICE_CAPACITY, dcap);
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                bw = 16'($urandom_range(0, 255));
                cap = 20'($urandom_range(0, 4095));
            end
            else if (mode < 7)
            begin
                bw = 16'($urandom_range(0, 2 * ((dbw[15:0] == 0) ? 1 : dbw[15:0])));
                cap = 20'($urandom_range(0, 2 * ((dcap == 0) ? 1 : dcap)));
            end
            else
            begin
                bw = 16'($urandom);
                cap = 20'($urandom);
            end
            send_request(bw, cap);
            if (hold_off && n == count / 2)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        unexpected = 0;
        unit_bw = 1;
        unit_cap = 1;
        for (int i = 0; i < wfca_pkg::NSLOTS; i++)
        begin
            comp_used[i] = 0;
            comp_bw[i] = 0;
            comp_cap[i] = 0;
            comp_devs[i] = 0;
        end
        for (int r = 0; r < wfca_pkg::RACKS; r++)
            rack_free[r] = wfca_pkg::DEVICES_PER_RACK;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(20'hFFFF, 20'hFFFFF, 270, 1'b1);
        test_random_phase(20'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                          270, 1'b0);
        test_random_phase(20'($urandom_range(1, 16)), 20'($urandom_range(1, 256)),
                          270, 1'b0);
        test_random_phase(20'($urandom_range(256, 65535)),
                          20'($urandom_range(4096, 1048575)), 270, 1'b0);
        test_random_phase(20'd1, 20'd1, 270, 1'b0);

        if (mismatches == 0 && unexpected == 0 && pending_grants.size() == 0)
            $display("worst_fit_composition_allocator_top regression: pass");
        else
            $display("worst_fit_composition_allocator_top regression: fail");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/wfca_pkg.sv
rtl/core/wfca_divider.sv
rtl/core/worst_fit_composition_allocator_top.sv
verif/tb.sv
